// ===== src/erot_pkg.sv =====
// Shared constants, register codes and the sine table generator for the rotation block.
package erot_pkg;

   localparam int ANGLE_BITS_DEF     = 12;
   localparam int COEF_FRAC_BITS_DEF = 14;
   localparam int VEC_WIDTH_DEF      = 16;

   // Width of the configuration register index.
   localparam int CSR_IDX_W = 2;

   localparam real PI = 3.14159265358979;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_YAW   = 2'd0,
      REG_PITCH = 2'd1,
      REG_ROLL  = 2'd2
   } csr_reg_type;

   // Entry k of the first-quadrant sine table, rounded half away from zero.
   function automatic int sin_entry(int k, int angle_bits, int frac_bits);
      real ang;
      real val;
      ang = 2.0 * PI * real'(k) * (2.0 ** (-angle_bits));
      val = $sin(ang) * (2.0 ** frac_bits);
      return $rtoi(val + 0.5);
   endfunction

endpackage

// ===== src/erot_coef.sv =====
// Rotation matrix builder: sine table lookups and the two matrix products.
module erot_coef #(
   parameter int ANGLE_BITS     = erot_pkg::ANGLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = erot_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ANGLE_BITS-1:0]            yaw_angle,
   input  logic [ANGLE_BITS-1:0]            pitch_angle,
   input  logic [ANGLE_BITS-1:0]            roll_angle,
   output logic                             busy,
   output logic signed [COEF_FRAC_BITS+1:0] mat [9]
);

   localparam int CW = COEF_FRAC_BITS + 2;
   localparam int PW = 2 * CW;
   localparam int M  = 1 << (ANGLE_BITS - 2);
   localparam int AW = ANGLE_BITS - 1;
   localparam int RW = ANGLE_BITS - 2;

   typedef logic signed [CW-1:0] rom_type [0:M];

   function automatic rom_type build_rom();
      rom_type t;
      for (int k = 0; k <= M; k++) begin
         t[k] = CW'(erot_pkg::sin_entry(k, ANGLE_BITS, COEF_FRAC_BITS));
      end
      return t;
   endfunction

   localparam rom_type SIN_ROM = build_rom();

   localparam logic signed [PW-1:0] BIAS = PW'(1) <<< (COEF_FRAC_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOOK, ST_DRAIN, ST_TRIG, ST_TMUL, ST_TRND, ST_RMUL, ST_RRND
   } state_type;

   state_type                state_ff;
   logic                     pending_ff;
   logic [2:0]               cnt_ff;
   logic                     rd_vld_ff;
   logic [2:0]               rd_idx_ff;
   logic signed [CW-1:0]     rom_q_ff;
   logic signed [CW-1:0]     raw_ff [6];
   logic signed [CW-1:0]     s_ff [3];
   logic signed [CW-1:0]     c_ff [3];
   logic signed [PW-1:0]     p_ff [4];
   logic signed [CW-1:0]     t_ff [9];
   logic signed [PW-1:0]     a_ff [3];
   logic signed [PW-1:0]     b_ff [3];
   logic signed [PW-1:0]     d_ff [3];
   logic signed [PW-1:0]     e_ff [3];
   logic signed [CW-1:0]     mat_ff [9];

   logic [ANGLE_BITS-1:0]    ang [3];
   logic [ANGLE_BITS-1:0]    cur_ang;
   logic [RW-1:0]            cur_r;
   logic [AW-1:0]            rom_addr;

   assign ang[0]  = yaw_angle;
   assign ang[1]  = pitch_angle;
   assign ang[2]  = roll_angle;
   assign cur_ang = ang[cnt_ff[2:1]];
   assign cur_r   = cur_ang[RW-1:0];

   // Even reads fetch sin(r), odd reads fetch sin(quarter - r), which is cos(r).
   assign rom_addr = cnt_ff[0] ? (AW'(M) - {1'b0, cur_r}) : {1'b0, cur_r};

   always_ff @(posedge clock) begin
      rom_q_ff <= SIN_ROM[rom_addr];
   end

   function automatic logic signed [CW-1:0] rnd(logic signed [PW:0] v);
      logic signed [PW:0] s;
      s = (v + (PW+1)'(BIAS)) >>> COEF_FRAC_BITS;
      return s[CW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pending_ff <= 1'b1;
         cnt_ff     <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            pending_ff <= 1'b1;
         end
         rd_vld_ff <= (state_ff == ST_LOOK);
         unique case (state_ff)
            ST_IDLE: begin
               if (pending_ff && !csr_we) begin
                  pending_ff <= 1'b0;
                  cnt_ff     <= '0;
                  state_ff   <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               rd_idx_ff <= cnt_ff;
               cnt_ff    <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd5) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: state_ff <= ST_TRIG;
            ST_TRIG: begin
               for (int a = 0; a < 3; a++) begin
                  case (ang[a][ANGLE_BITS-1 -: 2])
                     2'd0: begin
                        s_ff[a] <= raw_ff[2*a];
                        c_ff[a] <= raw_ff[2*a+1];
                     end
                     2'd1: begin
                        s_ff[a] <= raw_ff[2*a+1];
                        c_ff[a] <= -raw_ff[2*a];
                     end
                     2'd2: begin
                        s_ff[a] <= -raw_ff[2*a];
                        c_ff[a] <= -raw_ff[2*a+1];
                     end
                     default: begin
                        s_ff[a] <= -raw_ff[2*a+1];
                        c_ff[a] <= raw_ff[2*a];
                     end
                  endcase
               end
               state_ff <= ST_TMUL;
            end
            ST_TMUL: begin
               // Pitch is index 1, roll is index 2.
               p_ff[0]  <= PW'(c_ff[1]) * PW'(s_ff[2]);
               p_ff[1]  <= PW'(c_ff[1]) * PW'(c_ff[2]);
               p_ff[2]  <= PW'(s_ff[1]) * PW'(s_ff[2]);
               p_ff[3]  <= PW'(s_ff[1]) * PW'(c_ff[2]);
               state_ff <= ST_TRND;
            end
            ST_TRND: begin
               t_ff[0]  <= c_ff[2];
               t_ff[1]  <= -s_ff[2];
               t_ff[2]  <= '0;
               t_ff[3]  <= rnd((PW+1)'(p_ff[0]));
               t_ff[4]  <= rnd((PW+1)'(p_ff[1]));
               t_ff[5]  <= -s_ff[1];
               t_ff[6]  <= rnd((PW+1)'(p_ff[2]));
               t_ff[7]  <= rnd((PW+1)'(p_ff[3]));
               t_ff[8]  <= c_ff[1];
               state_ff <= ST_RMUL;
            end
            ST_RMUL: begin
               for (int j = 0; j < 3; j++) begin
                  a_ff[j] <= PW'(c_ff[0]) * PW'(t_ff[j]);
                  b_ff[j] <= PW'(s_ff[0]) * PW'(t_ff[6+j]);
                  e_ff[j] <= PW'(s_ff[0]) * PW'(t_ff[j]);
                  d_ff[j] <= PW'(c_ff[0]) * PW'(t_ff[6+j]);
               end
               state_ff <= ST_RRND;
            end
            ST_RRND: begin
               for (int j = 0; j < 3; j++) begin
                  mat_ff[j]   <= rnd((PW+1)'(a_ff[j]) + (PW+1)'(b_ff[j]));
                  mat_ff[3+j] <= t_ff[3+j];
                  mat_ff[6+j] <= rnd((PW+1)'(d_ff[j]) - (PW+1)'(e_ff[j]));
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         raw_ff[rd_idx_ff] <= rom_q_ff;
      end
   end

   assign busy = (state_ff != ST_IDLE) || pending_ff;
   assign mat  = mat_ff;

endmodule

// ===== src/euler_rotation_transform.sv =====
// Top level of the Euler rotation block: angle registers and the vector pipeline.
// Throughput: one vector per cycle while the matrix builder is not busy; the four-stage
// pipeline stalls only when rsp_ready is low. After reset and after every register write,
// the matrix is rebuilt from six reads of the single-port sine table, a quadrant step and
// four multiply and round steps; req_ready stays low meanwhile.
// Reset is synchronous and active high; it clears the angles to zero and the valid bits.
module euler_rotation_transform #(
   parameter int ANGLE_BITS     = erot_pkg::ANGLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = erot_pkg::COEF_FRAC_BITS_DEF,
   parameter int VEC_WIDTH      = erot_pkg::VEC_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [VEC_WIDTH-1:0]        req_in_x,
   input  logic signed [VEC_WIDTH-1:0]        req_in_y,
   input  logic signed [VEC_WIDTH-1:0]        req_in_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [VEC_WIDTH-1:0]        rsp_out_x,
   output logic signed [VEC_WIDTH-1:0]        rsp_out_y,
   output logic signed [VEC_WIDTH-1:0]        rsp_out_z,
   input  logic                               csr_we,
   input  logic [erot_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ANGLE_BITS-1:0]              csr_data
);

   localparam int CW = COEF_FRAC_BITS + 2;
   localparam int PW = VEC_WIDTH + CW;
   localparam int SW = PW + 2;

   localparam logic signed [SW-1:0] BIAS = SW'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [SW-1:0] VMAX = {{(SW-VEC_WIDTH+1){1'b0}}, {(VEC_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] VMIN = ~VMAX;

   // Angle registers. A write to an index beyond the list is dropped.
   logic [ANGLE_BITS-1:0] yaw_ff, pitch_ff, roll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff   <= '0;
         pitch_ff <= '0;
         roll_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            erot_pkg::REG_YAW:   yaw_ff   <= csr_data;
            erot_pkg::REG_PITCH: pitch_ff <= csr_data;
            erot_pkg::REG_ROLL:  roll_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // The matrix builder holds busy high from the write until the new matrix is in place.
   logic                 busy;
   logic signed [CW-1:0] mat [9];

   erot_coef #(
      .ANGLE_BITS     (ANGLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_coef (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .yaw_angle   (yaw_ff),
      .pitch_angle (pitch_ff),
      .roll_angle  (roll_ff),
      .busy        (busy),
      .mat         (mat)
   );

   // Four pipeline stages: input capture, nine products, three sums, round and saturate.
   // Each stage moves when it is empty or when the stage after it moves, so a stall at
   // the result port backs up stage by stage without losing or repeating a transfer.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;

   logic signed [VEC_WIDTH-1:0] vec_ff [3];
   logic signed [PW-1:0]        prod_ff [9];
   logic signed [SW-1:0]        sum_ff [3];
   logic signed [VEC_WIDTH-1:0] out_ff [3];
   logic signed [SW-1:0]        shifted [3];
   logic signed [VEC_WIDTH-1:0] sat [3];

   assign adv4 = !v4_ff || rsp_ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign req_ready = adv1 && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid && !busy;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         vec_ff[0] <= req_in_x;
         vec_ff[1] <= req_in_y;
         vec_ff[2] <= req_in_z;
      end
      if (adv2) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[3*r+c] <= PW'(mat[3*r+c]) * PW'(vec_ff[c]);
            end
         end
      end
      if (adv3) begin
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= SW'(prod_ff[3*i]) + SW'(prod_ff[3*i+1]) + SW'(prod_ff[3*i+2]) + BIAS;
         end
      end
      if (adv4) begin
         out_ff <= sat;
      end
   end

   // The rounding bias is already in the sum, so a floor shift completes the rounding.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shifted[i] = sum_ff[i] >>> COEF_FRAC_BITS;
         if (shifted[i] > VMAX) begin
            sat[i] = VMAX[VEC_WIDTH-1:0];
         end else if (shifted[i] < VMIN) begin
            sat[i] = VMIN[VEC_WIDTH-1:0];
         end else begin
            sat[i] = shifted[i][VEC_WIDTH-1:0];
         end
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];

endmodule

// ===== src/erot_checker.sv =====
// Port-level checks for the rotation block and the bind that attaches them.
module erot_checker #(
   parameter int VEC_WIDTH = erot_pkg::VEC_WIDTH_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [VEC_WIDTH-1:0] rsp_out_x,
   input logic signed [VEC_WIDTH-1:0] rsp_out_y,
   input logic signed [VEC_WIDTH-1:0] rsp_out_z,
   input logic                        csr_we
);

   // A stalled result holds its value until it is transferred.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
         && $stable(rsp_out_z))
      else $error("stalled result changed or dropped");

   // Reset empties the pipeline and starts a matrix rebuild.
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_ready)
      else $error("block not quiet after reset");

   // A register write blocks new vectors until the matrix is rebuilt.
   assert property (@(posedge clock) csr_we |=> !req_ready)
      else $error("vector accepted during matrix rebuild");

endmodule

bind euler_rotation_transform erot_checker #(.VEC_WIDTH(VEC_WIDTH)) u_erot_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_out_x (rsp_out_x),
   .rsp_out_y (rsp_out_y),
   .rsp_out_z (rsp_out_z),
   .csr_we    (csr_we)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the Euler angle vector rotation block.
`timescale 1ns / 1ps

module tb;

   localparam int VW = erot_pkg::VEC_WIDTH_DEF;
   localparam int AW = erot_pkg::ANGLE_BITS_DEF;
   localparam int FB = erot_pkg::COEF_FRAC_BITS_DEF;
   localparam longint VMAX = (64'sd1 <<< (VW - 1)) - 1;
   localparam longint VMIN = -VMAX - 1;
   // Index 3 is not a register; a write to it must change nothing.
   localparam logic [erot_pkg::CSR_IDX_W-1:0] REG_NONE = 2'd3;
   localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [VW-1:0] z;
   } vec_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid, req_ready;
   logic signed [VW-1:0] req_in_x, req_in_y, req_in_z;
   logic                 rsp_valid, rsp_ready;
   logic signed [VW-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic                 csr_we;
   logic [erot_pkg::CSR_IDX_W-1:0] csr_index;
   logic [AW-1:0]        csr_data;

   euler_rotation_transform dut (.*);

   always #4 clock = ~clock;

   // Vectors waiting to be offered and rotated vectors waiting to come back.
   vec_type pending_vecs[$];
   vec_type rotated_vecs[$];
   // Local copy of the angle registers and the rotation matrix built from them.
   logic [AW-1:0] yaw, pitch, roll;
   longint rot[9];
   // When set, neither side idles.
   logic   calm = 1'b0;
   int     mismatches = 0;
   int     vecs_sent = 0;
   int     vecs_checked = 0;
   int     hold_left = 0;

   // (a * b) >> 60 on Q60 fractions.
   function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // Taylor series for sine (odd) or cosine on the first octant, in Q60.
   function automatic logic [63:0] taylor_q60(logic [63:0] y, bit odd);
      logic [63:0] y2, term, acc, d;
      y2 = q60_mul(y, y);
      term = odd ? y : (64'd1 << 60);
      acc = term;
      for (int n = 1; n <= 14; n++) begin
         d = odd ? 64'(2 * n * (2 * n + 1)) : 64'((2 * n - 1) * 2 * n);
         term = q60_mul(term, y2) / d;
         if (n % 2) acc = acc - term;
         else acc = acc + term;
      end
      return acc;
   endfunction

   function automatic longint to_coef(logic [63:0] v);
      logic [63:0] t;
      t = (v + (64'd1 << (59 - FB))) >> (60 - FB);
      return longint'(t);
   endfunction

   // Exact sine and cosine of a binary angle as Q1.14 coefficients.
   task automatic angle_sincos(input logic [AW-1:0] k, output longint s, output longint c);
      int unsigned m, q, r;
      logic [63:0] y;
      longint sv, cv;
      m = 1 << (AW - 2);
      q = (k >> (AW - 2)) & 3;
      r = k & (m - 1);
      if (2 * r <= m) begin
         y = (HALF_PI_Q60 >> (AW - 2)) * r;
         sv = to_coef(taylor_q60(y, 1));
         cv = to_coef(taylor_q60(y, 0));
      end else begin
         y = (HALF_PI_Q60 >> (AW - 2)) * (m - r);
         sv = to_coef(taylor_q60(y, 0));
         cv = to_coef(taylor_q60(y, 1));
      end
      case (q)
         0: begin s = sv;  c = cv;  end
         1: begin s = cv;  c = -sv; end
         2: begin s = -sv; c = -cv; end
         default: begin s = -cv; c = sv; end
      endcase
   endtask

   // Round half up at the fraction point, then floor.
   function automatic longint round_frac(longint sum);
      return (sum + (64'sd1 <<< (FB - 1))) >>> FB;
   endfunction

   // Builds Ry * (Rx * Rz) from the current angles, rounding each product sum.
   task automatic rebuild_matrix();
      longint sy, cy, sp, cp, sr, cr, one;
      longint ry[9], rx[9], rz[9], t[9];
      one = 64'sd1 <<< FB;
      angle_sincos(yaw, sy, cy);
      angle_sincos(pitch, sp, cp);
      angle_sincos(roll, sr, cr);
      ry = '{cy, 0, sy, 0, one, 0, -sy, 0, cy};
      rx = '{one, 0, 0, 0, cp, -sp, 0, sp, cp};
      rz = '{cr, -sr, 0, sr, cr, 0, 0, 0, one};
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            t[i*3+j] = round_frac(rx[i*3]*rz[j] + rx[i*3+1]*rz[3+j] + rx[i*3+2]*rz[6+j]);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            rot[i*3+j] = round_frac(ry[i*3]*t[j] + ry[i*3+1]*t[3+j] + ry[i*3+2]*t[6+j]);
   endtask

   function automatic vec_type rotate_vec(vec_type v);
      longint in_c[3], o;
      logic signed [VW-1:0] res[3];
      in_c = '{longint'(v.x), longint'(v.y), longint'(v.z)};
      for (int i = 0; i < 3; i++) begin
         o = round_frac(rot[i*3]*in_c[0] + rot[i*3+1]*in_c[1] + rot[i*3+2]*in_c[2]);
         if (o > VMAX) o = VMAX;
         if (o < VMIN) o = VMIN;
         res[i] = o[VW-1:0];
      end
      return '{res[0], res[1], res[2]};
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // Driver: offers one vector at a time and records the rotated vector it should produce.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready) begin
         // Hold the offer until it is taken.
      end else begin
         if (req_valid) begin
            rotated_vecs.push_back(rotate_vec('{req_in_x, req_in_y, req_in_z}));
            vecs_sent++;
         end
         if (pending_vecs.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
            vec_type v;
            v = pending_vecs.pop_front();
            req_valid <= 1'b1;
            req_in_x <= v.x;
            req_in_y <= v.y;
            req_in_z <= v.z;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result transfer; once, it holds off for a long stretch
   // so that the pipeline fills and the input stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rotated_vecs.size() == 0) begin
               report_mismatch("unexpected result, x", rsp_out_x, 0);
            end else begin
               vec_type e;
               e = rotated_vecs.pop_front();
               if (rsp_out_x !== e.x) report_mismatch("out_x", rsp_out_x, e.x);
               if (rsp_out_y !== e.y) report_mismatch("out_y", rsp_out_y, e.y);
               if (rsp_out_z !== e.z) report_mismatch("out_z", rsp_out_z, e.z);
            end
            vecs_checked++;
            if (vecs_checked == 700) hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || $urandom_range(99) >= 21;
         end
      end
   end

   // Writes one register and updates the local matrix; it does not wait for the block to go idle.
   task automatic write_angle(input logic [erot_pkg::CSR_IDX_W-1:0] idx,
                              input logic [AW-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         erot_pkg::REG_YAW:   yaw = val;
         erot_pkg::REG_PITCH: pitch = val;
         erot_pkg::REG_ROLL:  roll = val;
         default: ;
      endcase
      rebuild_matrix();
   endtask

   task automatic set_angles(input logic [AW-1:0] y, input logic [AW-1:0] p,
                             input logic [AW-1:0] r);
      write_angle(erot_pkg::REG_YAW, y);
      write_angle(erot_pkg::REG_PITCH, p);
      write_angle(erot_pkg::REG_ROLL, r);
   endtask

   // Waits until every offered vector has come back, then lets the pipeline drain.
   task automatic drain();
      while (pending_vecs.size() != 0 || req_valid || rotated_vecs.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Mostly full-range vectors, with some small ones and some at the extremes.
   function automatic vec_type random_vec();
      logic signed [VW-1:0] c[3];
      int mode;
      mode = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
         if (mode < 6) c[i] = VW'($urandom);
         else if (mode < 8) c[i] = VW'($urandom_range(4000) - 2000);
         else c[i] = ($urandom_range(1)) ? VW'(VMAX) : VW'(VMIN);
      end
      return '{c[0], c[1], c[2]};
   endfunction

   function automatic logic [AW-1:0] random_angle();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return AW'($urandom_range(3) << (AW - 2));
         3: return AW'(($urandom_range(7) << (AW - 3)));
         default: return AW'($urandom);
      endcase
   endfunction

   initial begin
      logic signed [VW-1:0] ext[4];
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_x = '0;
      req_in_y = '0;
      req_in_z = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = erot_pkg::REG_YAW;
      csr_data = '0;
      yaw = '0;
      pitch = '0;
      roll = '0;
      rebuild_matrix();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: identity after reset, then extremes of the vector fields
      // under angles that hit quadrant and octant boundaries and the top angle.
      ext = '{VW'(VMAX), VW'(VMIN), VW'(0), VW'(-1)};
      for (int i = 0; i < 4; i++) pending_vecs.push_back('{ext[i], ext[3-i], ext[i]});
      drain();
      set_angles(AW'(1 << (AW - 3)), AW'(1 << (AW - 3)), AW'(1 << (AW - 3)));
      // Large equal components at an eighth of a turn push past the 16-bit range.
      pending_vecs.push_back('{VW'(VMAX), VW'(VMAX), VW'(VMAX)});
      pending_vecs.push_back('{VW'(VMIN), VW'(VMIN), VW'(VMIN)});
      pending_vecs.push_back('{VW'(VMAX), VW'(VMIN), VW'(0)});
      drain();
      set_angles('1, '1, '1);
      for (int i = 0; i < 4; i++) pending_vecs.push_back('{ext[i], ext[i], ext[3-i]});
      drain();
      set_angles(AW'(1 << (AW - 2)), AW'(2 << (AW - 2)), AW'(3 << (AW - 2)));
      // A write to the unused index must leave the angles alone.
      write_angle(REG_NONE, AW'(1234));
      for (int i = 0; i < 4; i++) pending_vecs.push_back('{ext[3-i], ext[i], ext[i]});
      pending_vecs.push_back('{VW'(1), VW'(2), VW'(3)});
      drain();

      // Random part: several angle settings, one of them with no idling at all.
      for (int ph = 0; ph < 8; ph++) begin
         set_angles(random_angle(), random_angle(), random_angle());
         calm = (ph == 2);
         for (int i = 0; i < 200; i++) pending_vecs.push_back(random_vec());
         drain();
      end
      calm = 1'b0;

      $display("Checked %0d rotated vectors over directed and random angle settings,",
               vecs_checked);
      $display("including saturation, quadrant boundaries and a long output stall.");
      if (mismatches == 0) begin
         $display("euler_rotation_transform test passed");
      end else begin
         $display("euler_rotation_transform test failed");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("euler_rotation_transform test failed");
      $finish;
   end

endmodule
